[rtl/core/ugam_pkg.sv]
// Package with the shared types, codes and constants of the graph adjacency store.
package ugam_pkg;

  localparam int unsigned DefMaxVertices = 16;
  localparam int unsigned OpW            = 3;
  localparam int unsigned ValueW         = 32;
  localparam int unsigned IndexW         = 4;
  localparam int unsigned StatusW        = 2;
  localparam int unsigned CountOutW      = 5;
  localparam int unsigned RowOutW        = 16;
  localparam int unsigned MaxOut         = 16;

  typedef enum logic [OpW-1:0] {
    OP_ADD_VERTEX = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_ADD_EDGE   = 3'd2,
    OP_DEL_EDGE   = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RM_WALK,
    S_EDGE_A,
    S_EDGE_B,
    S_DUMP_WALK,
    S_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    in_ready;
    logic    add_wr;
    logic    edge_rd_a;
    logic    edge_wr_a;
    logic    edge_wr_b;
    logic    walk_start;
    logic    walk_step;
    logic    rm_done;
    logic    code_wr;
    status_e code;
    logic    resp_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic           in_fire;
    logic [OpW-1:0] op;
    logic           full;
    logic           empty;
    logic           rm_bad;
    logic           edge_bad;
    logic           single;
    logic           walk_last;
    logic           out_free;
  } flags_t;

endpackage

[rtl/core/ugam_in_if.sv]
// Operation channel interface: valid, ready and one operation item.
interface ugam_in_if;
  import ugam_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OpW-1:0]           op;
  logic signed [ValueW-1:0] vertex_value;
  logic [IndexW-1:0]        first_index;
  logic [IndexW-1:0]        second_index;

  modport source (output valid, op, vertex_value, first_index, second_index, input ready);
  modport sink   (input valid, op, vertex_value, first_index, second_index, output ready);
endinterface

[rtl/core/ugam_out_if.sv]
// Result channel interface: valid, ready and one result item.
interface ugam_out_if;
  import ugam_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [StatusW-1:0]       status;
  logic [CountOutW-1:0]     vertex_count;
  logic signed [ValueW-1:0] row_value;
  logic [RowOutW-1:0]       row_bits;
  logic                     last;

  modport source (output valid, status, vertex_count, row_value, row_bits, last, input ready);
  modport sink   (input valid, status, vertex_count, row_value, row_bits, last, output ready);
endinterface

[rtl/core/ugam_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module ugam_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule

[rtl/core/ugam_ctrl.sv]
// Controller state machine that sequences each graph operation.
module ugam_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ugam_pkg::flags_t flags_i,
  output ugam_pkg::cmd_t  cmd_o
);
  import ugam_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (flags_i.in_fire) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (op_e'(flags_i.op))
          OP_REMOVE: begin
            if (flags_i.empty || flags_i.rm_bad || flags_i.single) state_d = S_RESP;
            else state_d = S_RM_WALK;
          end
          OP_ADD_EDGE, OP_DEL_EDGE: begin
            if (flags_i.edge_bad) state_d = S_RESP;
            else state_d = S_EDGE_A;
          end
          OP_DUMP: begin
            if (flags_i.empty) state_d = S_RESP;
            else state_d = S_DUMP_WALK;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_RM_WALK: begin
        if (flags_i.walk_last) state_d = S_RESP;
      end
      S_EDGE_A:  state_d = S_EDGE_B;
      S_EDGE_B:  state_d = S_RESP;
      S_DUMP_WALK: begin
        if (flags_i.out_free && flags_i.walk_last) state_d = S_IDLE;
      end
      S_RESP: begin
        if (flags_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    cmd_o.code = ST_OK;
    unique case (state_q)
      S_IDLE: cmd_o.in_ready = 1'b1;
      S_DECIDE: begin
        cmd_o.code_wr = 1'b1;
        unique case (op_e'(flags_i.op))
          OP_ADD_VERTEX: begin
            if (flags_i.full) cmd_o.code = ST_FULL;
            else cmd_o.add_wr = 1'b1;
          end
          OP_REMOVE: begin
            if (flags_i.empty) cmd_o.code = ST_EMPTY;
            else if (flags_i.rm_bad) cmd_o.code = ST_BAD_INDEX;
            else if (flags_i.single) cmd_o.rm_done = 1'b1;
            else cmd_o.walk_start = 1'b1;
          end
          OP_ADD_EDGE, OP_DEL_EDGE: begin
            if (flags_i.edge_bad) cmd_o.code = ST_BAD_INDEX;
            else cmd_o.edge_rd_a = 1'b1;
          end
          OP_DUMP: begin
            if (flags_i.empty) cmd_o.code = ST_EMPTY;
            else cmd_o.walk_start = 1'b1;
          end
          default: cmd_o.code = ST_OK;
        endcase
      end
      S_RM_WALK: begin
        cmd_o.walk_step = 1'b1;
        cmd_o.rm_done   = flags_i.walk_last;
      end
      S_EDGE_A:    cmd_o.edge_wr_a = 1'b1;
      S_EDGE_B:    cmd_o.edge_wr_b = 1'b1;
      S_DUMP_WALK: cmd_o.walk_step = flags_i.out_free;
      S_RESP:      cmd_o.resp_load = flags_i.out_free;
      default:     cmd_o.in_ready  = 1'b0;
    endcase
  end
endmodule

[rtl/core/ugam_dp.sv]
// Datapath: operation registers, vertex count, row store and result register.
module ugam_dp #(
  parameter int unsigned MaxVertices = ugam_pkg::DefMaxVertices
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ugam_in_if.sink          in_i,
  ugam_out_if.source       out_o,
  input  ugam_pkg::cmd_t   cmd_i,
  output ugam_pkg::flags_t flags_o
);
  import ugam_pkg::*;

  localparam int unsigned RowW    = MaxVertices;
  localparam int unsigned AddrW   = $clog2(MaxVertices);
  localparam int unsigned CntW    = $clog2(MaxVertices + 1);
  localparam int unsigned WordW   = ValueW + RowW;
  localparam int unsigned WalkMax = (MaxVertices < MaxOut) ? MaxVertices : MaxOut;

  // Removes column idx from a row and moves the higher columns down by one.
  function automatic logic [RowW-1:0] squeeze(logic [RowW-1:0] row, logic [AddrW-1:0] idx);
    logic [RowW-1:0] low_mask;
    low_mask = (RowW'(1) << idx) - RowW'(1);
    return (row & low_mask) | (((row >> idx) >> 1) << idx);
  endfunction

  logic [OpW-1:0]           op_q;
  logic signed [ValueW-1:0] value_q;
  logic [IndexW-1:0]        a_q, b_q;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          k_q, k_d;
  status_e                  code_q;

  logic                     out_valid_q, out_valid_d;
  logic [StatusW-1:0]       out_status_q;
  logic [CountOutW-1:0]     out_count_q;
  logic signed [ValueW-1:0] out_value_q;
  logic [RowOutW-1:0]       out_bits_q;
  logic                     out_last_q;

  logic                     in_fire, is_rm, set_edge, out_load, walk_last;
  logic [CntW-1:0]          walk_len, idx_c, k_next, src_x, src_addr;
  logic [AddrW-1:0]         a_addr, b_addr;
  logic                     rd_en, wr_en;
  logic [AddrW-1:0]         rd_addr, wr_addr;
  logic [WordW-1:0]         wr_data, rd_data;
  logic [ValueW-1:0]        rd_val;
  logic [RowW-1:0]          rd_row;

  assign in_i.ready = cmd_i.in_ready;
  assign in_fire    = in_i.valid && cmd_i.in_ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= in_i.op;
      value_q <= in_i.vertex_value;
      a_q     <= in_i.first_index;
      b_q     <= in_i.second_index;
    end
    if (cmd_i.code_wr) begin
      code_q <= cmd_i.code;
    end
  end

  assign is_rm    = (op_q == OP_REMOVE);
  assign set_edge = (op_q == OP_ADD_EDGE);
  assign a_addr   = AddrW'(a_q);
  assign b_addr   = AddrW'(b_q);
  assign idx_c    = CntW'(a_q);
  assign k_next   = k_q + CntW'(1);

  assign walk_len  = is_rm ? (count_q - CntW'(1))
                           : ((count_q < CntW'(WalkMax)) ? count_q : CntW'(WalkMax));
  assign walk_last = (k_next == walk_len);

  // Source row of a walk step: removal skips the deleted row.
  assign src_x    = cmd_i.walk_start ? '0 : k_next;
  assign src_addr = (is_rm && !(src_x < idx_c)) ? (src_x + CntW'(1)) : src_x;

  assign rd_val = rd_data[WordW-1:RowW];
  assign rd_row = rd_data[RowW-1:0];

  always_comb begin
    rd_en = cmd_i.edge_rd_a || cmd_i.edge_wr_a || cmd_i.walk_start || cmd_i.walk_step;
    priority if (cmd_i.edge_rd_a) rd_addr = a_addr;
    else if (cmd_i.edge_wr_a)     rd_addr = b_addr;
    else                          rd_addr = AddrW'(src_addr);
  end

  always_comb begin
    wr_en = cmd_i.add_wr || cmd_i.edge_wr_a || cmd_i.edge_wr_b || (cmd_i.walk_step && is_rm);
    priority if (cmd_i.add_wr) begin
      wr_addr = AddrW'(count_q);
      wr_data = {value_q, RowW'(0)};
    end else if (cmd_i.edge_wr_a) begin
      wr_addr = a_addr;
      wr_data = {rd_val, set_edge ? (rd_row | (RowW'(1) << b_addr))
                                  : (rd_row & ~(RowW'(1) << b_addr))};
    end else if (cmd_i.edge_wr_b) begin
      wr_addr = b_addr;
      wr_data = {rd_val, set_edge ? (rd_row | (RowW'(1) << a_addr))
                                  : (rd_row & ~(RowW'(1) << a_addr))};
    end else begin
      wr_addr = AddrW'(k_q);
      wr_data = {rd_val, squeeze(rd_row, a_addr)};
    end
  end

  ugam_ram #(
    .Width (WordW),
    .Depth (MaxVertices)
  ) u_rows (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.add_wr)       count_d = count_q + CntW'(1);
    else if (cmd_i.rm_done) count_d = count_q - CntW'(1);
    k_d = k_q;
    if (cmd_i.walk_start)     k_d = '0;
    else if (cmd_i.walk_step) k_d = k_next;
  end

  assign out_load    = cmd_i.resp_load || (cmd_i.walk_step && !is_rm);
  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q <= CountOutW'(count_q);
      if (cmd_i.resp_load) begin
        out_status_q <= code_q;
        out_value_q  <= '0;
        out_bits_q   <= '0;
        out_last_q   <= 1'b1;
      end else begin
        out_status_q <= ST_OK;
        out_value_q  <= rd_val;
        out_bits_q   <= RowOutW'(rd_row);
        out_last_q   <= walk_last;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.vertex_count = out_count_q;
  assign out_o.row_value    = out_value_q;
  assign out_o.row_bits     = out_bits_q;
  assign out_o.last         = out_last_q;

  always_comb begin
    flags_o.in_fire   = in_fire;
    flags_o.op        = op_q;
    flags_o.full      = (count_q == CntW'(MaxVertices));
    flags_o.empty     = (count_q == '0);
    flags_o.rm_bad    = !(8'(a_q) < 8'(count_q));
    flags_o.edge_bad  = !(8'(a_q) < 8'(count_q)) || !(8'(b_q) < 8'(count_q)) || (a_q == b_q);
    flags_o.single    = (count_q == CntW'(1));
    flags_o.walk_last = walk_last;
    flags_o.out_free  = !out_valid_q || out_o.ready;
  end
endmodule

[rtl/core/undirected_graph_adjacency_matrix_core.sv]
// Top level of the undirected graph store kept as an adjacency bit matrix.
// Ready is high only while idle; a waiting result does not hold back the next transfer in.
// Each item is accepted, decided, then walked, edge-updated or answered directly; the block
// takes no new item until it has loaded the last result of the current one.
// Reset is asynchronous and active low; it empties the graph and needs no clearing pass.
module undirected_graph_adjacency_matrix_core #(
  parameter int unsigned MaxVertices = ugam_pkg::DefMaxVertices
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ugam_in_if.sink     in_i,
  ugam_out_if.source  out_o
);
  import ugam_pkg::*;

  // The controller decides each step of an operation; the datapath holds the
  // vertex count, the operation registers, the row store and the result register.
  // Each row store word holds the vertex value above its row of adjacency bits.
  // Rows at or above the vertex count are never read before being written, since
  // adding a vertex writes its whole word, and edge bits above the count are
  // always clear, so the store itself needs no reset.
  cmd_t   cmd;
  flags_t flags;

  ugam_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .cmd_o   (cmd)
  );

  // Removal rewrites every surviving row in one pass: each write takes the row
  // read in the cycle before, drops the removed column, and lands one place
  // lower past the removed index. A dump transfers one row per cycle and holds
  // the row read data while the result channel stalls.
  ugam_dp #(
    .MaxVertices (MaxVertices)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .cmd_i   (cmd),
    .flags_o (flags)
  );
endmodule
